FILE: src/cidnb_pkg.sv
// Shared types, constants and helper functions for the citizen number check/build block.
`timescale 1ns / 1ps
`default_nettype none

package cidnb_pkg;

  localparam int NumW            = 44;
  localparam int DigitCnt        = 13;
  localparam int BcdW            = 4 * DigitCnt;
  localparam int DdStepsPerStage = 8;
  localparam int DdStages        = (NumW + DdStepsPerStage - 1) / DdStepsPerStage;
  localparam int CfgW            = 10;

  localparam logic [NumW-1:0] Ten13           = 44'd10000000000000;
  localparam logic [CfgW-1:0] RecentYearMaxRst = 10'd17;
  localparam logic [CfgW-1:0] OldYearMinRst    = 10'd917;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_BUILD  = 1'b1
  } cidnb_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DATE  = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_CHECK_TEN = 2'd3
  } cidnb_status_t;

  typedef enum logic {
    REG_RECENT_YEAR_MAX = 1'b0,
    REG_OLD_YEAR_MIN    = 1'b1
  } cidnb_reg_t;

  typedef struct packed {
    cidnb_op_t   opcode;
    logic [43:0] id_number;
    logic [6:0]  birth_day;
    logic [6:0]  birth_month;
    logic [13:0] birth_year;
    logic [6:0]  region_code;
    logic        is_female_in;
  } cidnb_req_t;

  typedef struct packed {
    cidnb_status_t status;
    logic [43:0]   number;
    logic [6:0]    day;
    logic [6:0]    month;
    logic [13:0]   year;
    logic [6:0]    region;
    logic [9:0]    sex_code;
    logic          is_female;
  } cidnb_res_t;

  // after field extraction and date check
  typedef struct packed {
    cidnb_op_t   opcode;
    logic        bad;
    logic [9:0]  wsum;
    logic [3:0]  chk_given;
    logic [13:0] hi;
    logic [16:0] mid;
    cidnb_res_t  res;
  } cidnb_f1_t;

  // after check digit and upper number part
  typedef struct packed {
    cidnb_op_t   opcode;
    logic [3:0]  cdig;
    logic [30:0] hm;
    cidnb_res_t  res;
  } cidnb_f2_t;

  // one double-dabble step: add-3 correction on every digit, then shift in a bit
  function automatic logic [BcdW-1:0] dd_shift(logic [BcdW-1:0] bcd, logic din);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DigitCnt; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], din};
  endfunction

  // v / 10 for v < 128, by reciprocal multiply
  function automatic logic [3:0] div10(logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [6:0] two_dig(logic [3:0] t, logic [3:0] u);
    return 7'(7'(t) * 7'd10) + 7'(u);
  endfunction

  function automatic logic [9:0] three_dig(logic [3:0] h, logic [3:0] t, logic [3:0] u);
    return 10'(10'(h) * 10'd100) + 10'(10'(t) * 10'd10) + 10'(u);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: src/cidnb_bcd_pipe.sv
// Pipelined binary to 13-digit BCD converter that carries the request word alongside.
`timescale 1ns / 1ps
`default_nettype none

module cidnb_bcd_pipe (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire cidnb_pkg::cidnb_req_t        in_req,
  input  wire logic [cidnb_pkg::NumW-1:0]   in_bin,
  output logic                              out_valid,
  output cidnb_pkg::cidnb_req_t             out_req,
  output logic [cidnb_pkg::BcdW-1:0]        out_bcd
);

  localparam int Stages = cidnb_pkg::DdStages;
  localparam int NumW   = cidnb_pkg::NumW;
  localparam int BcdW   = cidnb_pkg::BcdW;

  logic                  valid_r [Stages];
  cidnb_pkg::cidnb_req_t req_r   [Stages];
  logic [BcdW-1:0]       bcd_r   [Stages];
  logic [NumW-1:0]       src_r   [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    localparam int Done  = s * cidnb_pkg::DdStepsPerStage;
    localparam int Steps = (NumW - Done < cidnb_pkg::DdStepsPerStage) ?
                           (NumW - Done) : cidnb_pkg::DdStepsPerStage;

    logic                  v_in;
    cidnb_pkg::cidnb_req_t req_in;
    logic [BcdW-1:0]       bcd_in;
    logic [BcdW-1:0]       bcd_nxt;
    logic [NumW-1:0]       src_in;
    logic [NumW-1:0]       src_nxt;

    if (s == 0) begin : g_first
      assign v_in   = in_valid;
      assign req_in = in_req;
      assign bcd_in = '0;
      assign src_in = in_bin;
    end else begin : g_next
      assign v_in   = valid_r[s-1];
      assign req_in = req_r[s-1];
      assign bcd_in = bcd_r[s-1];
      assign src_in = src_r[s-1];
    end

    // source is consumed MSB first
    always_comb begin
      bcd_nxt = bcd_in;
      src_nxt = src_in;
      for (int k = 0; k < Steps; k++) begin
        bcd_nxt = cidnb_pkg::dd_shift(bcd_nxt, src_nxt[NumW-1]);
        src_nxt = {src_nxt[NumW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= v_in;
      end
      if (en) begin
        req_r[s] <= req_in;
        bcd_r[s] <= bcd_nxt;
        src_r[s] <= src_nxt;
      end
    end
  end

  assign out_valid = valid_r[Stages-1];
  assign out_req   = req_r[Stages-1];
  assign out_bcd   = bcd_r[Stages-1];

endmodule

`default_nettype wire

FILE: src/id_number_check_and_build.sv
// Top level: citizen number decode/validate and build with weighted mod-11 check digit.
`timescale 1ns / 1ps
`default_nettype none

// Takes one word per clock while in_stall is low and returns one result word
// per input word, in order. Opcode decode splits the 13-digit number
// DDMMYYYRRSSSC, maps the year through the two configurable windows, checks
// the date (Gregorian leap rule) and the check digit; opcode build checks date
// and region and forms the number with its check digit. A result passes through
// an input register, six binary-to-BCD stages (eight bits per stage, four in
// the last), field/date stage, check-digit stage, and the output register.
// Behind the output register sits a one-word skid register; in_stall rises
// only while that skid holds a word. The user must write the year window registers
// through cfg_* only while no word is in flight; the block does not enforce it.

module id_number_check_and_build (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [43:0] in_id_number,
  input  wire logic [6:0]  in_birth_day,
  input  wire logic [6:0]  in_birth_month,
  input  wire logic [13:0] in_birth_year,
  input  wire logic [6:0]  in_region_code,
  input  wire logic        in_is_female_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [43:0]      out_number_out,
  output logic [6:0]       out_day_out,
  output logic [6:0]       out_month_out,
  output logic [13:0]      out_year_out,
  output logic [6:0]       out_region_out,
  output logic [9:0]       out_sex_code,
  output logic             out_is_female_out
);

  localparam int NumW = cidnb_pkg::NumW;
  localparam int BcdW = cidnb_pkg::BcdW;
  localparam int CfgW = cidnb_pkg::CfgW;

  logic                  en;
  logic [CfgW-1:0]       recent_year_max_r;
  logic [CfgW-1:0]       old_year_min_r;

  logic                  s0_valid_r;
  cidnb_pkg::cidnb_req_t s0_req_r;
  logic [NumW-1:0]       s0_bin;

  logic                  p_valid;
  cidnb_pkg::cidnb_req_t p_req;
  logic [BcdW-1:0]       p_bcd;

  logic                  f1_valid_r;
  cidnb_pkg::cidnb_f1_t  f1_r;
  cidnb_pkg::cidnb_f1_t  f1_nxt;
  logic                  f2_valid_r;
  cidnb_pkg::cidnb_f2_t  f2_r;
  cidnb_pkg::cidnb_f2_t  f2_nxt;

  cidnb_pkg::cidnb_res_t res;
  logic                  res_valid;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  cidnb_pkg::cidnb_res_t out_r;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  cidnb_pkg::cidnb_res_t skid_r;
  logic                  load_out;
  logic                  load_skid;
  logic                  out_from_skid;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_year_max_r <= cidnb_pkg::RecentYearMaxRst;
      old_year_min_r    <= cidnb_pkg::OldYearMinRst;
    end else if (cfg_we) begin
      unique case (cidnb_pkg::cidnb_reg_t'(cfg_index))
        cidnb_pkg::REG_RECENT_YEAR_MAX: recent_year_max_r <= cfg_wdata;
        cidnb_pkg::REG_OLD_YEAR_MIN:    old_year_min_r    <= cfg_wdata;
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
    if (en) begin
      s0_req_r.opcode       <= cidnb_pkg::cidnb_op_t'(in_opcode);
      s0_req_r.id_number    <= in_id_number;
      s0_req_r.birth_day    <= in_birth_day;
      s0_req_r.birth_month  <= in_birth_month;
      s0_req_r.birth_year   <= in_birth_year;
      s0_req_r.region_code  <= in_region_code;
      s0_req_r.is_female_in <= in_is_female_in;
    end
  end

  // 44 bits never reach 2 * 10^13, so one subtract keeps the low 13 digits.
  // Build mode converts the year instead, to get its decimal digits.
  always_comb begin
    if (s0_req_r.opcode == cidnb_pkg::OP_BUILD) begin
      s0_bin = NumW'(s0_req_r.birth_year);
    end else if (s0_req_r.id_number >= cidnb_pkg::Ten13) begin
      s0_bin = s0_req_r.id_number - cidnb_pkg::Ten13;
    end else begin
      s0_bin = s0_req_r.id_number;
    end
  end

  cidnb_bcd_pipe u_bcd_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_valid_r),
    .in_req    (s0_req_r),
    .in_bin    (s0_bin),
    .out_valid (p_valid),
    .out_req   (p_req),
    .out_bcd   (p_bcd)
  );

  // ---------------- fields, date check, weighted sum ----------------
  always_comb begin
    logic [3:0]  dg [13];
    logic [3:0]  a  [12];
    logic [6:0]  dec_day, dec_mon, dec_reg;
    logic [9:0]  dec_y3, dec_sex, enc_y3;
    logic [13:0] dec_year;
    logic        recent, yok, build;
    logic [3:0]  day_t, day_u, mon_t, mon_u, reg_t, reg_u;
    logic [6:0]  u7;
    logic [6:0]  chk_day, chk_mon;
    logic [13:0] chk_year;
    logic [3:0]  yr_tens, yr_units;
    logic [1:0]  cent;
    logic        leap, date_ok;
    logic [4:0]  lim;

    for (int i = 0; i < 13; i++) begin
      dg[i] = p_bcd[4*(12-i) +: 4];
    end
    build = (p_req.opcode == cidnb_pkg::OP_BUILD);

    dec_day = cidnb_pkg::two_dig(dg[0], dg[1]);
    dec_mon = cidnb_pkg::two_dig(dg[2], dg[3]);
    dec_y3  = cidnb_pkg::three_dig(dg[4], dg[5], dg[6]);
    dec_reg = cidnb_pkg::two_dig(dg[7], dg[8]);
    dec_sex = cidnb_pkg::three_dig(dg[9], dg[10], dg[11]);

    // recent window wins when the two overlap
    recent = (dec_y3 <= recent_year_max_r);
    yok    = 1'b1;
    if (recent) begin
      dec_year = 14'd2000 + 14'(dec_y3);
    end else if (dec_y3 >= old_year_min_r) begin
      dec_year = 14'd1000 + 14'(dec_y3);
    end else begin
      dec_year = '0;
      yok      = 1'b0;
    end

    day_t = cidnb_pkg::div10(p_req.birth_day);
    u7    = p_req.birth_day - 7'(7'(day_t) * 7'd10);
    day_u = u7[3:0];
    mon_t = cidnb_pkg::div10(p_req.birth_month);
    u7    = p_req.birth_month - 7'(7'(mon_t) * 7'd10);
    mon_u = u7[3:0];
    reg_t = cidnb_pkg::div10(p_req.region_code);
    u7    = p_req.region_code - 7'(7'(reg_t) * 7'd10);
    reg_u = u7[3:0];
    // in build mode the converted value is the year: low three digits give y mod 1000
    enc_y3 = cidnb_pkg::three_dig(dg[10], dg[11], dg[12]);

    // leap test: binary year mod 4, century count mod 4 and last two decimal digits
    if (build) begin
      chk_day  = p_req.birth_day;
      chk_mon  = p_req.birth_month;
      chk_year = p_req.birth_year;
      yr_tens  = dg[11];
      yr_units = dg[12];
      cent     = {dg[9][0], 1'b0} + dg[10][1:0];
    end else begin
      chk_day  = dec_day;
      chk_mon  = dec_mon;
      chk_year = dec_year;
      yr_tens  = dg[5];
      yr_units = dg[6];
      cent     = dg[4][1:0] + {!recent, 1'b0};
    end
    leap = (chk_year[1:0] == 2'b00) &&
           (!(yr_tens == 4'd0 && yr_units == 4'd0) || cent == 2'd0);
    lim  = cidnb_pkg::month_len(chk_mon[3:0]);
    if (chk_mon == 7'd2 && leap) begin
      lim = lim + 5'd1;
    end
    date_ok = (chk_year != '0) && (chk_day != '0) && (chk_mon >= 7'd1) &&
              (chk_mon <= 7'd12) && (chk_day <= 7'(lim));

    if (build) begin
      a[0] = day_t;  a[1] = day_u;  a[2] = mon_t;  a[3]  = mon_u;
      a[4] = dg[10]; a[5] = dg[11]; a[6] = dg[12]; a[7]  = reg_t;
      a[8] = reg_u;  a[9] = p_req.is_female_in ? 4'd5 : 4'd0;
      a[10] = 4'd0;  a[11] = 4'd0;
    end else begin
      for (int i = 0; i < 12; i++) begin
        a[i] = dg[i];
      end
    end

    f1_nxt.opcode    = p_req.opcode;
    f1_nxt.chk_given = dg[12];
    f1_nxt.wsum      = 10'(10'd7 * (10'(a[0]) + 10'(a[6]))) +
                       10'(10'd6 * (10'(a[1]) + 10'(a[7]))) +
                       10'(10'd5 * (10'(a[2]) + 10'(a[8]))) +
                       10'(10'd4 * (10'(a[3]) + 10'(a[9]))) +
                       10'(10'd3 * (10'(a[4]) + 10'(a[10]))) +
                       10'(10'd2 * (10'(a[5]) + 10'(a[11])));
    f1_nxt.hi  = 14'(14'(p_req.birth_day) * 14'd100) + 14'(p_req.birth_month);
    f1_nxt.mid = 17'(17'(enc_y3) * 17'd100) + 17'(p_req.region_code);

    f1_nxt.res.status = cidnb_pkg::ST_OK;
    if (build) begin
      f1_nxt.bad           = !date_ok || (p_req.region_code > 7'd99);
      f1_nxt.res.number    = '0;
      f1_nxt.res.day       = p_req.birth_day;
      f1_nxt.res.month     = p_req.birth_month;
      f1_nxt.res.year      = p_req.birth_year;
      f1_nxt.res.region    = p_req.region_code;
      f1_nxt.res.sex_code  = p_req.is_female_in ? 10'd500 : 10'd0;
      f1_nxt.res.is_female = p_req.is_female_in;
    end else begin
      f1_nxt.bad           = !yok || !date_ok;
      f1_nxt.res.number    = p_req.id_number;
      f1_nxt.res.day       = dec_day;
      f1_nxt.res.month     = dec_mon;
      f1_nxt.res.year      = dec_year;
      f1_nxt.res.region    = dec_reg;
      f1_nxt.res.sex_code  = dec_sex;
      f1_nxt.res.is_female = (dec_sex >= 10'd500);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= p_valid;
    end
    if (en) begin
      f1_r <= f1_nxt;
    end
  end

  // ---------------- check digit, status ----------------
  always_comb begin
    logic [18:0] qp;
    logic [6:0]  q;
    logic [9:0]  r10;
    logic [3:0]  r;

    // sum <= 486 on any accepted path: (s * 373) >> 12 == s / 11
    qp  = 19'(f1_r.wsum) * 19'd373;
    q   = qp[18:12];
    r10 = f1_r.wsum - 10'(10'(q) * 10'd11);
    r   = r10[3:0];

    f2_nxt.opcode = f1_r.opcode;
    f2_nxt.cdig   = (r == 4'd0) ? 4'd0 : 4'd11 - r;
    f2_nxt.hm     = 31'(31'(f1_r.hi) * 31'd100000) + 31'(f1_r.mid);
    f2_nxt.res    = f1_r.res;
    priority if (f1_r.bad) begin
      f2_nxt.res.status = cidnb_pkg::ST_BAD_DATE;
    end else if (f2_nxt.cdig == 4'd10) begin
      f2_nxt.res.status = cidnb_pkg::ST_CHECK_TEN;
    end else if (f1_r.opcode == cidnb_pkg::OP_DECODE && f2_nxt.cdig != f1_r.chk_given) begin
      f2_nxt.res.status = cidnb_pkg::ST_MISMATCH;
    end else begin
      f2_nxt.res.status = cidnb_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f2_valid_r <= f1_valid_r;
    end
    if (en) begin
      f2_r <= f2_nxt;
    end
  end

  // ---------------- number assembly ----------------
  always_comb begin
    logic [NumW-1:0] num;
    num = NumW'(NumW'(f2_r.hm) * NumW'(14'd10000)) +
          NumW'(NumW'(f2_r.res.sex_code) * NumW'(4'd10)) + NumW'(f2_r.cdig);
    res = f2_r.res;
    if (f2_r.opcode == cidnb_pkg::OP_BUILD) begin
      res.number = (f2_r.res.status == cidnb_pkg::ST_OK) ? num : '0;
    end
  end

  assign res_valid = f2_valid_r && en;

  // ---------------- output register and skid ----------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_out       = 1'b0;
    load_skid      = 1'b0;
    out_from_skid  = 1'b0;
    if (out_valid_r && !out_stall) begin
      if (skid_valid_r) begin
        out_from_skid  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (res_valid) begin
        load_out = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (out_valid_r) begin
      if (res_valid) begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end else if (res_valid) begin
      load_out      = 1'b1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    if (load_out) begin
      out_r <= res;
    end else if (out_from_skid) begin
      out_r <= skid_r;
    end
    if (load_skid) begin
      skid_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_number_out    = out_r.number;
  assign out_day_out       = out_r.day;
  assign out_month_out     = out_r.month;
  assign out_year_out      = out_r.year;
  assign out_region_out    = out_r.region;
  assign out_sex_code      = out_r.sex_code;
  assign out_is_female_out = out_r.is_female;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output word");

  a_female_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.is_female == (out_r.sex_code >= 10'd500)))
    else $error("female flag disagrees with sex code");

  a_ok_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == cidnb_pkg::ST_OK) |-> (out_r.number != '0))
    else $error("accepted word reports a zero number");

endmodule

`default_nettype wire
